// ----- src/skvt_pkg.sv -----
// skvt_pkg: shared types, constants and status codes of the sorted key/value table
// depends on nothing
`default_nettype none
package skvt_pkg;
   localparam int unsigned DEPTH = 256;
   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = AW + 1;
   localparam logic [31:0] RESERVED_KEY = 32'hFFFF_FFFF;

   localparam logic [1:0] KIND_ADD  = 2'd0;
   localparam logic [1:0] KIND_FIND = 2'd1;
   localparam logic [1:0] KIND_DEL  = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_MISS     = 3'd1;
   localparam logic [2:0] ST_RESERVED = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_EMPTY    = 3'd4;
   localparam logic [2:0] ST_BADIDX   = 3'd5;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] key;
      logic [31:0] value;
      logic [7:0]  entry_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  found_index;
      logic [31:0] found_value;
      logic [7:0]  entry_count;
   } rsp_type;
endpackage
`default_nettype wire

// ----- src/skvt_if.sv -----
// skvt_if: valid/ready channel carrying one payload struct
// depends on skvt_pkg
`default_nettype none
interface skvt_req_if;
   logic valid;
   logic ready;
   skvt_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface skvt_rsp_if;
   logic valid;
   logic ready;
   skvt_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/sorted_key_value_table.sv -----
// sorted_key_value_table: sorted key/value store with binary search find
// depends on skvt_pkg and skvt_if
//
// channel  dir  payload
// req      in   kind, key, value, entry_index
// rsp      out  status, found_index, found_value, entry_count
// csr      in   table_limit write (9 bits)
//
// one request at a time; both stores sit in rams with a registered read
// add: walks down from the top, reading and shifting one entry at a time (up to count shifts)
// delete: one read per shifted entry from the index up
// find: one read per probe of the binary search, up to 8 probes
// reset clears count, sets limit to 256 and returns to idle; rsp stall holds the result until taken
`default_nettype none
module sorted_key_value_table (
   input  wire logic  clock,
   input  wire logic  reset,
   skvt_req_if.sink   req,
   skvt_rsp_if.source rsp,
   input  wire logic       csr_write,
   input  wire logic [8:0] csr_data
);
   import skvt_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_ADD  = 3'd2;
   localparam logic [2:0] S_DEL  = 3'd3;
   localparam logic [2:0] S_FIND = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [31:0] key_mem [DEPTH];
   logic [31:0] val_mem [DEPTH];

   logic [2:0]  state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [8:0]  limit_ff;
   req_type     cur_ff, cur_in;
   rsp_type     res_ff, res_in;
   logic [CW-1:0] pos_ff, pos_in;      // walking position
   logic signed [CW:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [AW-1:0] mid;
   logic [AW-1:0] rd_addr;
   logic        rd_en;
   logic [31:0] rd_key, rd_val;
   logic        wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0] wr_key, wr_val;
   logic [9:0]  eff_limit;

   // memories
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         val_mem[wr_addr] <= wr_val;
      end
      if (rd_en) begin
         rd_key <= key_mem[rd_addr];
         rd_val <= val_mem[rd_addr];
      end
   end

   assign eff_limit = (limit_ff > 9'(DEPTH)) ? 10'(DEPTH) : {1'b0, limit_ff};
   assign mid = AW'(lo_ff + ((hi_ff - lo_ff) >>> 1));
   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.data = res_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cur_in = cur_ff;
      res_in = res_ff;
      pos_in = pos_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      rd_en = 1'b0;
      rd_addr = '0;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_key = cur_ff.key;
      wr_val = cur_ff.value;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               cur_in = req.data;
               res_in = '{status: ST_OK, found_index: '0, found_value: '0,
                          entry_count: count_ff[7:0]};
               state_in = S_OUT;
               case (req.data.kind)
                  KIND_ADD: begin
                     if (req.data.key == RESERVED_KEY) res_in.status = ST_RESERVED;
                     else if (10'(count_ff) + 10'd1 >= eff_limit) res_in.status = ST_FULL;
                     else begin
                        pos_in = count_ff;
                        state_in = S_ADD;
                     end
                  end
                  KIND_FIND: begin
                     lo_in = '0;
                     hi_in = $signed({1'b0, count_ff}) - 10'sd1;
                     res_in.status = ST_MISS;
                     state_in = S_FIND;
                  end
                  KIND_DEL: begin
                     if (count_ff == '0) res_in.status = ST_EMPTY;
                     else if (CW'(req.data.entry_index) >= count_ff)
                        res_in.status = ST_BADIDX;
                     else begin
                        pos_in = CW'(req.data.entry_index);
                        state_in = S_DEL;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // add: issue read of pos-1, or place the new pair
         S_ADD: begin
            if (pos_ff == '0) begin
               wr_en = 1'b1;
               wr_addr = '0;
               count_in = count_ff + 1'b1;
               res_in.entry_count = 8'(count_ff + 1'b1);
               state_in = S_OUT;
            end else begin
               rd_en = 1'b1;
               rd_addr = AW'(pos_ff - 1'b1);
               state_in = S_RD;
            end
         end
         // delete: read pos+1 while inside the table, else shrink
         S_DEL: begin
            if (pos_ff + 1'b1 >= count_ff) begin
               count_in = count_ff - 1'b1;
               res_in.entry_count = 8'(count_ff - 1'b1);
               state_in = S_OUT;
            end else begin
               rd_en = 1'b1;
               rd_addr = AW'(pos_ff + 1'b1);
               state_in = S_RD;
            end
         end
         // read data back: shift one entry or insert
         S_RD: begin
            if (cur_ff.kind == KIND_ADD) begin
               wr_en = 1'b1;
               if (rd_key > cur_ff.key) begin
                  wr_addr = AW'(pos_ff);
                  wr_key = rd_key;
                  wr_val = rd_val;
                  pos_in = pos_ff - 1'b1;
                  state_in = S_ADD;
               end else begin
                  wr_addr = AW'(pos_ff);
                  count_in = count_ff + 1'b1;
                  res_in.entry_count = 8'(count_ff + 1'b1);
                  state_in = S_OUT;
               end
            end else if (cur_ff.kind == KIND_DEL) begin
               wr_en = 1'b1;
               wr_addr = AW'(pos_ff);
               wr_key = rd_key;
               wr_val = rd_val;
               pos_in = pos_ff + 1'b1;
               state_in = S_DEL;
            end else begin
               // find probe compare
               if (cur_ff.key < rd_key) hi_in = $signed({1'b0, CW'(mid)}) - 10'sd1;
               else if (cur_ff.key > rd_key) lo_in = $signed({1'b0, CW'(mid)}) + 10'sd1;
               else begin
                  res_in.status = ST_OK;
                  res_in.found_index = 8'(mid);
                  res_in.found_value = rd_val;
                  state_in = S_OUT;
               end
               if (cur_ff.key != rd_key) state_in = S_FIND;
            end
         end
         // find: issue next probe
         S_FIND: begin
            if (lo_ff > hi_ff) state_in = S_OUT;
            else begin
               rd_en = 1'b1;
               rd_addr = mid;
               state_in = S_RD;
            end
         end
         S_OUT: begin
            if (rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         limit_ff <= 9'd256;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_write) limit_ff <= csr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      res_ff <= res_in;
      pos_ff <= pos_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

`ifndef SYNTH
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff < CW'(DEPTH)) else $error("count overflow");
   a_one: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("ready during result");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> $stable(res_ff)) else $error("result changed");
`endif
endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// tb: self-checking bench for sorted_key_value_table with a sorted-table predictor
// depends on skvt_pkg, skvt_if and the sorted_key_value_table rtl
`default_nettype none

// scoreboard: mirrors the table contents and queues expected responses
class skvt_scoreboard;
   logic [31:0] key_mem [256];
   logic [31:0] val_mem [256];
   int unsigned count;
   int unsigned limit;
   skvt_pkg::rsp_type pending_rsp [$];
   int mismatches;

   function void clear();
      count = 0;
      limit = 256;
      mismatches = 0;
      pending_rsp.delete();
   endfunction

   // predict the response of one accepted request
   function void note_request(skvt_pkg::req_type r);
      skvt_pkg::rsp_type e;
      int pos;
      int lo;
      int hi;
      int mid;
      int unsigned lim;
      e = '0;
      e.status = skvt_pkg::ST_OK;
      lim = (limit > 256) ? 256 : limit;
      case (r.kind)
         skvt_pkg::KIND_ADD: begin
            if (r.key == skvt_pkg::RESERVED_KEY) e.status = skvt_pkg::ST_RESERVED;
            else if (count + 1 >= lim) e.status = skvt_pkg::ST_FULL;
            else begin
               // stable insert after equal keys
               pos = count;
               while (pos > 0 && key_mem[pos-1] > r.key) begin
                  key_mem[pos] = key_mem[pos-1];
                  val_mem[pos] = val_mem[pos-1];
                  pos--;
               end
               key_mem[pos] = r.key;
               val_mem[pos] = r.value;
               count++;
            end
         end
         skvt_pkg::KIND_FIND: begin
            e.status = skvt_pkg::ST_MISS;
            lo = 0;
            hi = int'(count) - 1;
            while (lo <= hi) begin
               mid = lo + (hi - lo) / 2;
               if (r.key < key_mem[mid]) hi = mid - 1;
               else if (r.key > key_mem[mid]) lo = mid + 1;
               else begin
                  e.status = skvt_pkg::ST_OK;
                  e.found_index = mid[7:0];
                  e.found_value = val_mem[mid];
                  break;
               end
            end
         end
         skvt_pkg::KIND_DEL: begin
            if (count == 0) e.status = skvt_pkg::ST_EMPTY;
            else if (r.entry_index >= count) e.status = skvt_pkg::ST_BADIDX;
            else begin
               for (int i = r.entry_index; i + 1 < count; i++) begin
                  key_mem[i] = key_mem[i+1];
                  val_mem[i] = val_mem[i+1];
               end
               count--;
            end
         end
         default: ;
      endcase
      e.entry_count = count[7:0];
      pending_rsp.push_back(e);
   endfunction

   // compare one accepted response with the oldest prediction
   function void check_response(skvt_pkg::rsp_type a);
      skvt_pkg::rsp_type e;
      if (pending_rsp.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected response %h", a);
         return;
      end
      e = pending_rsp.pop_front();
      if (a.status !== e.status || a.found_index !== e.found_index ||
          a.found_value !== e.found_value || a.entry_count !== e.entry_count) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected st=%0d idx=%0d val=%h cnt=%0d got st=%0d idx=%0d val=%h cnt=%0d",
                     e.status, e.found_index, e.found_value, e.entry_count,
                     a.status, a.found_index, a.found_value, a.entry_count);
      end
   endfunction
endclass

module tb;
   // kind code with no operation behind it
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic clock;
   logic reset;
   logic csr_write;
   logic [8:0] csr_data;
   skvt_req_if req ();
   skvt_rsp_if rsp ();
   skvt_scoreboard table_model;
   bit calm_phase;
   bit hold_rsp;
   longint cycle_count;

   sorted_key_value_table dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_write(csr_write), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // response sink: random stalls, plus a long hold when requested
   initial begin
      int gap;
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp.valid && rsp.ready) table_model.check_response(rsp.data);
         if (hold_rsp) rsp.ready <= 1'b0;
         else if (!calm_phase && $urandom_range(0, 7) == 0) begin
            rsp.ready <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap - 1) begin
               @(posedge clock);
               if (rsp.valid && rsp.ready) table_model.check_response(rsp.data);
            end
         end else rsp.ready <= 1'b1;
      end
   end

   // timeout watchdog
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 4000000) begin
            $display("[sorted_key_value_table] ERROR");
            $finish;
         end
      end
   end

   // offer one request and wait for acceptance, with random leading gaps
   // valid stays up after acceptance so back-to-back requests need one update
   task automatic send_request(skvt_pkg::req_type r);
      if (!calm_phase && $urandom_range(0, 5) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.data <= r;
      do @(posedge clock); while (!req.ready);
      table_model.note_request(r);
   endtask

   task automatic wait_idle();
      req.valid <= 1'b0;
      while (table_model.pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_limit(logic [8:0] lim);
      csr_write <= 1'b1;
      csr_data <= lim;
      @(posedge clock);
      csr_write <= 1'b0;
      table_model.limit = lim;
   endtask

   function automatic skvt_pkg::req_type make_req(logic [1:0] k, logic [31:0] key,
                                                 logic [31:0] v, logic [7:0] idx);
      skvt_pkg::req_type r;
      r.kind = k;
      r.key = key;
      r.value = v;
      r.entry_index = idx;
      return r;
   endfunction

   // random request; finds are biased toward keys already in the table
   task automatic send_random(int unsigned key_span);
      skvt_pkg::req_type r;
      int unsigned pick;
      int unsigned c;
      c = table_model.count;
      pick = $urandom_range(0, 99);
      r.value = $urandom();
      r.key = (key_span == 0) ? $urandom() : $urandom_range(0, key_span);
      r.entry_index = (c > 0 && $urandom_range(0, 3) != 0) ?
                      8'($urandom_range(0, c - 1)) : 8'($urandom());
      if (pick < 45) r.kind = skvt_pkg::KIND_ADD;
      else if (pick < 75) begin
         r.kind = skvt_pkg::KIND_FIND;
         if (c > 0 && $urandom_range(0, 1)) r.key = table_model.key_mem[$urandom_range(0, c - 1)];
      end else if (pick < 97) r.kind = skvt_pkg::KIND_DEL;
      else r.kind = KIND_UNUSED;
      if ($urandom_range(0, 40) == 0) r.key = skvt_pkg::RESERVED_KEY;
      send_request(r);
   endtask

   initial begin
      table_model = new();
      table_model.clear();
      calm_phase = 1'b0;
      hold_rsp = 1'b0;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_data = '0;
      req.valid = 1'b0;
      req.data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty delete, miss, reserved key, extremes, equal keys, unused kind
      send_request(make_req(skvt_pkg::KIND_DEL, 32'd0, 32'd0, 8'd0));
      send_request(make_req(skvt_pkg::KIND_FIND, 32'd5, 32'd0, 8'd0));
      send_request(make_req(skvt_pkg::KIND_ADD, skvt_pkg::RESERVED_KEY, 32'd1, 8'd0));
      send_request(make_req(skvt_pkg::KIND_ADD, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 8'd0));
      send_request(make_req(skvt_pkg::KIND_ADD, 32'd0, 32'd0, 8'd0));
      send_request(make_req(skvt_pkg::KIND_ADD, 32'd7, 32'h1111_1111, 8'd0));
      send_request(make_req(skvt_pkg::KIND_ADD, 32'd7, 32'h2222_2222, 8'd0));
      send_request(make_req(skvt_pkg::KIND_ADD, 32'd7, 32'h3333_3333, 8'd0));
      send_request(make_req(skvt_pkg::KIND_FIND, 32'd7, 32'd0, 8'd0));
      send_request(make_req(skvt_pkg::KIND_FIND, 32'hFFFF_FFFE, 32'd0, 8'd0));
      send_request(make_req(skvt_pkg::KIND_FIND, 32'd0, 32'd0, 8'd0));
      send_request(make_req(skvt_pkg::KIND_FIND, skvt_pkg::RESERVED_KEY, 32'd0, 8'd0));
      send_request(make_req(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
      send_request(make_req(skvt_pkg::KIND_DEL, 32'd0, 32'd0, 8'hFF));
      send_request(make_req(skvt_pkg::KIND_DEL, 32'd0, 32'd0, 8'd5));
      send_request(make_req(skvt_pkg::KIND_DEL, 32'd0, 32'd0, 8'd4));
      send_request(make_req(skvt_pkg::KIND_DEL, 32'd0, 32'd0, 8'd0));
      wait_idle();

      // limit of 2 refuses an add while the table holds an entry, accepts it once empty
      write_limit(9'd2);
      send_request(make_req(skvt_pkg::KIND_ADD, 32'd1, 32'd1, 8'd0));
      send_request(make_req(skvt_pkg::KIND_DEL, 32'd0, 32'd0, 8'd0));
      send_request(make_req(skvt_pkg::KIND_DEL, 32'd0, 32'd0, 8'd0));
      send_request(make_req(skvt_pkg::KIND_DEL, 32'd0, 32'd0, 8'd0));
      send_request(make_req(skvt_pkg::KIND_ADD, 32'd1, 32'd1, 8'd0));
      wait_idle();

      // largest limit, with a long response hold while requests keep coming
      write_limit(9'd511);
      fork
         begin
            hold_rsp = 1'b1;
            repeat (3000) @(posedge clock);
            hold_rsp = 1'b0;
         end
         repeat (20) send_random(0);
      join
      wait_idle();

      // random phases over several limits, small key space to get duplicates
      write_limit(9'd12);
      repeat (300) send_random(40);
      wait_idle();
      write_limit(9'd256);
      repeat (300) send_random(0);
      wait_idle();
      // fill the table completely, then drain with deletes
      write_limit(9'd300);
      repeat (260) send_request(make_req(skvt_pkg::KIND_ADD, $urandom(), $urandom(), 8'd0));
      repeat (40) send_random(0);
      repeat (260) send_request(make_req(skvt_pkg::KIND_DEL, 32'd0, 32'd0,
                                         8'($urandom_range(0, 255))));
      wait_idle();
      write_limit(9'd33);
      repeat (300) send_random(1000);
      wait_idle();
      calm_phase = 1'b1;
      write_limit(9'd100);
      repeat (150) send_random(200);
      wait_idle();
      repeat (600) @(posedge clock);

      if (table_model.mismatches == 0 && table_model.pending_rsp.size() == 0)
         $display("[sorted_key_value_table] OK");
      else
         $display("[sorted_key_value_table] ERROR");
      $finish;
   end
endmodule
`default_nettype wire
